@@ design/hcd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcd_pkg: shared definitions for the HTTP chunked decoder
// Parse modes, end status codes, line and size limits, and the header text
// that marks a chunked body.
// ----------------------------------------------------------------------------
package hcd_pkg;

   // Longest size line held, CRLF included.
   localparam int SIZE_LINE_MAX   = 20;
   // Width of the chunk size counter; larger sizes saturate.
   localparam int CHUNK_SIZE_BITS = 32;

   localparam int LINE_LEN_W = $clog2(SIZE_LINE_MAX + 1);
   localparam int LINE_IDX_W = $clog2(SIZE_LINE_MAX);

   // Header text searched for, first character in the top byte.
   localparam int WIN_LEN = 26;
   localparam logic [8*WIN_LEN-1:0] TE_TEXT = "Transfer-Encoding: chunked";

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_ZERO = 8'h30;

   typedef enum logic [2:0] {
      MODE_HEADER,
      MODE_SIZE,
      MODE_DATA,
      MODE_SKIP,
      MODE_RAW,
      MODE_DONE,
      MODE_PLAIN
   } mode_type;

   typedef enum logic [2:0] {
      ST_ZERO_CHUNK,
      ST_NOT_CHUNKED,
      ST_RAW_BAD_LINE,
      ST_TRUNCATED,
      ST_BETWEEN_CHUNKS
   } end_status_type;

endpackage
`default_nettype wire

@@ design/http_chunked_decoder.sv @@
`default_nettype none
// A data byte appears in the result register in the cycle after its request.
// Throughput (rsp_stall low): one request per cycle; a request with end marker and a
// data byte stalls requests until its status result is sent; a rejected size line
// stalls requests as the line buffer drains up to SIZE_LINE_MAX bytes, one a cycle.
// Reset: synchronous, clears parse state, header window and result valid; the line
// buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// http_chunked_decoder: HTTP/1.1 chunked transfer decoder
// Passes header bytes, detects the chunked encoding header, parses hex size
// lines incrementally and emits chunk data, with a status result at the end.
// ----------------------------------------------------------------------------
module http_chunked_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_present,
   output logic            rsp_out_last,
   output logic [2:0]      rsp_end_status
);

   localparam int CSB   = hcd_pkg::CHUNK_SIZE_BITS;
   localparam int LEN_W = hcd_pkg::LINE_LEN_W;
   localparam int IDX_W = hcd_pkg::LINE_IDX_W;
   localparam int WIN   = hcd_pkg::WIN_LEN;

   // Decodes one hex character to {valid, value}.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30;
         return {1'b1, t[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         t = c - 8'h57;
         return {1'b1, t[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         t = c - 8'h37;
         return {1'b1, t[3:0]};
      end
      return 5'b0_0000;
   endfunction

   // Parse state.
   hcd_pkg::mode_type mode_ff, mode_in;
   logic              seen_ff, seen_in;
   logic [7:0]        win_ff [WIN];
   logic [7:0]        buf_ff [hcd_pkg::SIZE_LINE_MAX];
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ok_ff, ok_in;
   logic [CSB-1:0]    acc_ff, acc_in;
   logic              pok_ff, pok_in;
   logic [CSB-1:0]    pacc_ff, pacc_in;
   logic              pcr_ff, pcr_in;
   logic              fz_ff, fz_in;
   logic [CSB-1:0]    rem_ff, rem_in;
   logic [1:0]        skip_ff, skip_in;

   // Result side.
   logic              rsp_valid_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_present_ff;
   logic              rsp_last_ff;
   logic [2:0]        rsp_status_ff;
   logic [LEN_W-1:0]  drain_cnt_ff;
   logic [IDX_W-1:0]  drain_idx_ff;
   logic              stat_pend_ff;
   logic [2:0]        stat_val_ff;

   logic              slot_free;
   logic              accept;
   logic              emit_byte;
   logic              flush;
   logic              buf_we;
   logic              win_shift;
   logic              te_match;
   logic              hdr_end;
   logic [4:0]        hex;
   logic [LEN_W-1:0]  len_new;
   logic              line_end;
   logic [CSB-1:0]    acc_step;
   hcd_pkg::end_status_type status;

   // Handshake.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !slot_free || (drain_cnt_ff != '0) || stat_pend_ff;
   assign accept    = req_valid && !req_stall;

   // Header window compare on the window as it stands after this byte.
   always_comb begin
      te_match = (req_in_byte == hcd_pkg::TE_TEXT[7:0]);
      for (int i = 0; i < WIN - 1; i++) begin
         if (win_ff[i+1] != hcd_pkg::TE_TEXT[8*(WIN-1-i) +: 8]) begin
            te_match = 1'b0;
         end
      end
      hdr_end = (win_ff[WIN-3] == hcd_pkg::CH_CR) && (win_ff[WIN-2] == hcd_pkg::CH_LF) &&
                (win_ff[WIN-1] == hcd_pkg::CH_CR) && (req_in_byte == hcd_pkg::CH_LF);
   end

   // Size line helpers: hex digit, saturating accumulate and line end.
   assign hex      = hex_decode(req_in_byte);
   assign len_new  = len_ff + 1'b1;
   assign line_end = (len_ff != '0) && (req_in_byte == hcd_pkg::CH_LF) && pcr_ff;
   assign acc_step = (acc_ff[CSB-1:CSB-4] != 4'h0) ? {CSB{1'b1}} : {acc_ff[CSB-5:0], hex[3:0]};

   // Next parse state and the results that this request causes.
   always_comb begin
      mode_in   = mode_ff;
      seen_in   = seen_ff;
      len_in    = len_ff;
      ok_in     = ok_ff;
      acc_in    = acc_ff;
      pok_in    = pok_ff;
      pacc_in   = pacc_ff;
      pcr_in    = pcr_ff;
      fz_in     = fz_ff;
      rem_in    = rem_ff;
      skip_in   = skip_ff;
      emit_byte = 1'b0;
      flush     = 1'b0;
      buf_we    = 1'b0;
      win_shift = 1'b0;
      status    = hcd_pkg::ST_BETWEEN_CHUNKS;

      if (accept) begin
         case (mode_ff)
            hcd_pkg::MODE_HEADER: begin
               emit_byte = 1'b1;
               win_shift = 1'b1;
               seen_in   = seen_ff || te_match;
               if (hdr_end) begin
                  mode_in = seen_in ? hcd_pkg::MODE_SIZE : hcd_pkg::MODE_PLAIN;
                  len_in  = '0;
                  ok_in   = 1'b1;
                  acc_in  = '0;
                  pcr_in  = 1'b0;
               end
            end
            hcd_pkg::MODE_PLAIN, hcd_pkg::MODE_RAW: begin
               emit_byte = 1'b1;
            end
            hcd_pkg::MODE_SIZE: begin
               buf_we = 1'b1;
               if (line_end) begin
                  // The hex text is everything before the closing CR.
                  if (len_ff == LEN_W'(2) && fz_ff) begin
                     mode_in = hcd_pkg::MODE_DONE;
                     len_in  = '0;
                  end else if (len_ff == LEN_W'(1) || !pok_ff) begin
                     flush   = 1'b1;
                     mode_in = hcd_pkg::MODE_RAW;
                     len_in  = '0;
                  end else begin
                     len_in = '0;
                     rem_in = pacc_ff;
                     if (pacc_ff == '0) begin
                        mode_in = hcd_pkg::MODE_SKIP;
                        skip_in = 2'd2;
                     end else begin
                        mode_in = hcd_pkg::MODE_DATA;
                     end
                  end
               end else if (len_new >= LEN_W'(hcd_pkg::SIZE_LINE_MAX)) begin
                  flush   = 1'b1;
                  mode_in = hcd_pkg::MODE_RAW;
                  len_in  = '0;
               end else begin
                  len_in  = len_new;
                  pok_in  = ok_ff;
                  pacc_in = acc_ff;
                  ok_in   = ok_ff && hex[4];
                  acc_in  = acc_step;
                  pcr_in  = (req_in_byte == hcd_pkg::CH_CR);
                  if (len_ff == '0) begin
                     fz_in = (req_in_byte == hcd_pkg::CH_ZERO);
                  end
               end
            end
            hcd_pkg::MODE_DATA: begin
               emit_byte = 1'b1;
               if (rem_ff != '0) begin
                  rem_in = rem_ff - 1'b1;
               end
               if (rem_in == '0) begin
                  mode_in = hcd_pkg::MODE_SKIP;
                  skip_in = 2'd2;
               end
            end
            hcd_pkg::MODE_SKIP: begin
               if (skip_ff != 2'd0) begin
                  skip_in = skip_ff - 1'b1;
               end
               if (skip_in == 2'd0) begin
                  mode_in = hcd_pkg::MODE_SIZE;
                  len_in  = '0;
                  ok_in   = 1'b1;
                  acc_in  = '0;
                  pcr_in  = 1'b0;
               end
            end
            default: begin
            end
         endcase

         // End of response: report and return to the reset state.
         case (mode_in)
            hcd_pkg::MODE_DONE:   status = hcd_pkg::ST_ZERO_CHUNK;
            hcd_pkg::MODE_HEADER,
            hcd_pkg::MODE_PLAIN:  status = hcd_pkg::ST_NOT_CHUNKED;
            hcd_pkg::MODE_RAW:    status = hcd_pkg::ST_RAW_BAD_LINE;
            hcd_pkg::MODE_DATA:   status = hcd_pkg::ST_TRUNCATED;
            default:              status = hcd_pkg::ST_BETWEEN_CHUNKS;
         endcase
         if (req_in_last) begin
            mode_in = hcd_pkg::MODE_HEADER;
            seen_in = 1'b0;
            len_in  = '0;
            rem_in  = '0;
            skip_in = 2'd0;
         end
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hcd_pkg::MODE_HEADER;
         seen_ff <= 1'b0;
         len_ff  <= '0;
         rem_ff  <= '0;
         skip_ff <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         seen_ff <= seen_in;
         len_ff  <= len_in;
         rem_ff  <= rem_in;
         skip_ff <= skip_in;
      end
      ok_ff   <= ok_in;
      acc_ff  <= acc_in;
      pok_ff  <= pok_in;
      pacc_ff <= pacc_in;
      pcr_ff  <= pcr_in;
      fz_ff   <= fz_in;
   end

   // Header window shift register, cleared at the end of each response.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_in_last)) begin
         for (int i = 0; i < WIN; i++) begin
            win_ff[i] <= 8'h00;
         end
      end else if (win_shift) begin
         for (int i = 0; i < WIN - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[WIN-1] <= req_in_byte;
      end
   end

   // Size line buffer.
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[len_ff[IDX_W-1:0]] <= req_in_byte;
      end
   end

   // Result register, line buffer drain and pending status result.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         drain_cnt_ff <= '0;
         stat_pend_ff <= 1'b0;
      end else if (accept) begin
         stat_val_ff <= status;
         if (flush) begin
            rsp_valid_ff <= 1'b0;
            drain_cnt_ff <= len_new;
            drain_idx_ff <= '0;
            stat_pend_ff <= req_in_last;
         end else if (emit_byte) begin
            rsp_valid_ff   <= 1'b1;
            rsp_byte_ff    <= req_in_byte;
            rsp_present_ff <= 1'b1;
            rsp_last_ff    <= 1'b0;
            rsp_status_ff  <= hcd_pkg::ST_ZERO_CHUNK;
            stat_pend_ff   <= req_in_last;
         end else if (req_in_last) begin
            rsp_valid_ff   <= 1'b1;
            rsp_byte_ff    <= 8'h00;
            rsp_present_ff <= 1'b0;
            rsp_last_ff    <= 1'b1;
            rsp_status_ff  <= status;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end else if (slot_free) begin
         if (drain_cnt_ff != '0) begin
            rsp_valid_ff   <= 1'b1;
            rsp_byte_ff    <= buf_ff[drain_idx_ff];
            rsp_present_ff <= 1'b1;
            rsp_last_ff    <= 1'b0;
            rsp_status_ff  <= hcd_pkg::ST_ZERO_CHUNK;
            drain_cnt_ff   <= drain_cnt_ff - 1'b1;
            drain_idx_ff   <= drain_idx_ff + 1'b1;
         end else if (stat_pend_ff) begin
            rsp_valid_ff   <= 1'b1;
            rsp_byte_ff    <= 8'h00;
            rsp_present_ff <= 1'b0;
            rsp_last_ff    <= 1'b1;
            rsp_status_ff  <= stat_val_ff;
            stat_pend_ff   <= 1'b0;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_byte_present = rsp_present_ff;
   assign rsp_out_last     = rsp_last_ff;
   assign rsp_end_status   = rsp_status_ff;

endmodule
`default_nettype wire
